// File: src/aifs_pkg.sv
// Shared types, codes and character helpers for the ASCII integer field scanner.
package aifs_pkg;

    // Width of the consumed-character counter (saturates at all ones).
    localparam int CNT_BITS = 16;

    // Field modes as carried on the mode input.
    typedef logic [2:0] t_mode;
    localparam t_mode MODE_DEC  = 3'd0;
    localparam t_mode MODE_AUTO = 3'd1;
    localparam t_mode MODE_OCT  = 3'd2;
    localparam t_mode MODE_UDEC = 3'd3;
    localparam t_mode MODE_HEX  = 3'd4;

    // Result size selection.
    typedef logic [1:0] t_size;
    localparam t_size SIZE_WORD  = 2'd0;
    localparam t_size SIZE_SHORT = 2'd1;
    localparam t_size SIZE_LONG  = 2'd2;

    // Number base of the digits being accumulated.
    typedef logic [1:0] t_base;
    localparam t_base BASE_DEC = 2'd0;
    localparam t_base BASE_OCT = 2'd1;
    localparam t_base BASE_HEX = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;

    // Marker returned for a character that is no hex digit.
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Digit value of a hex digit character, DIGIT_NONE otherwise.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                t = c - CH_ZERO;
                hex_val = t[4:0];
            end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
                t = c - CH_LOW_A + 8'd10;
                hex_val = t[4:0];
            end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                t = c - CH_UP_A + 8'd10;
                hex_val = t[4:0];
            end else begin
                hex_val = DIGIT_NONE;
            end
        end
    endfunction

    // Radix limit for a base: a digit is valid when below this value.
    function automatic logic [4:0] base_radix(input t_base b);
        begin
            unique case (b)
                BASE_OCT: base_radix = 5'd8;
                BASE_HEX: base_radix = 5'd16;
                default:  base_radix = 5'd10;
            endcase
        end
    endfunction

endpackage

// File: src/ascii_integer_field_scanner.sv
// Top level of the ASCII integer field scanner: per-character field state and result register.
// Throughput: one character beat per cycle while the result side keeps up.
// The result of a field appears in the cycle after the beat that ends it
// (the first character not taken, or the character that reaches the width limit).
// The accumulator update is one constant multiply-add by shifts, so each beat
// is processed combinationally between the field state and the result register.
// Synchronous active-low reset returns to idle with no field open and no result pending.
module ascii_integer_field_scanner #(
    parameter int VALUE_BITS = 64,
    parameter int WIDTH_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Character channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_ch,
    input  logic                          i_start_req,
    input  aifs_pkg::t_mode               i_mode,
    input  aifs_pkg::t_size               i_size_sel,
    input  logic [WIDTH_BITS-1:0]         i_max_width,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic [aifs_pkg::CNT_BITS-1:0] o_consumed,
    output logic                          o_good
);
    import aifs_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_AUTO_ZERO,
        PH_HEX_ZERO,
        PH_DIGITS
    } t_phase;

    // Field state
    t_phase                r_phase,  n_phase;
    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic [CNT_BITS-1:0]   r_cnt,    n_cnt;
    logic                  r_neg,    n_neg;
    logic                  r_ok,     n_ok;
    t_base                 r_base,   n_base;
    t_mode                 r_mode,   n_mode;
    logic [WIDTH_BITS-1:0] r_width,  n_width;
    t_size                 r_size,   n_size;

    // Result register
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_value,  n_value;
    logic [CNT_BITS-1:0]   r_consumed;
    logic                  r_good;

    logic                  accept;
    logic                  emit;
    logic                  take;
    logic                  add;
    t_base                 add_base;
    logic [4:0]            dig;
    logic [VALUE_BITS-1:0] acc_scaled;
    logic [VALUE_BITS-1:0] dig_ext;
    logic [VALUE_BITS-1:0] size_mask;

    // A new beat is taken unless a finished result is stalled.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign dig        = hex_val(i_ch);

    // Per-character decode and state update.
    always_comb begin
        // A start beat opens a fresh field with the sampled settings.
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_ok    = r_ok;
        n_base  = r_base;
        n_mode  = r_mode;
        n_width = r_width;
        n_size  = r_size;
        if (i_start_req) begin
            n_mode  = (i_mode > MODE_HEX) ? MODE_DEC : i_mode;
            n_size  = i_size_sel;
            n_width = i_max_width;
            n_acc   = '0;
            n_cnt   = '0;
            n_neg   = 1'b0;
            n_ok    = 1'b0;
            n_base  = BASE_DEC;
            n_phase = PH_LEAD;
        end

        take     = 1'b0;
        add      = 1'b0;
        add_base = BASE_DEC;

        // Decide whether the character belongs to the field.
        unique case (n_phase)
            PH_IDLE: begin
                take = 1'b0;
            end
            PH_LEAD: begin
                priority if ((i_ch == CH_MINUS || i_ch == CH_PLUS) && n_cnt == '0) begin
                    n_neg = (i_ch == CH_MINUS);
                    take  = 1'b1;
                end else if (n_mode == MODE_AUTO) begin
                    priority if (i_ch == CH_ZERO) begin
                        n_ok    = 1'b1;
                        n_phase = PH_AUTO_ZERO;
                        take    = 1'b1;
                    end else if (dig < 5'd10) begin
                        add = 1'b1; add_base = BASE_DEC;
                    end else begin
                        take = 1'b0;
                    end
                end else if (n_mode == MODE_HEX) begin
                    priority if (i_ch == CH_ZERO) begin
                        n_ok    = 1'b1;
                        n_phase = PH_HEX_ZERO;
                        take    = 1'b1;
                    end else if (dig < 5'd16) begin
                        add = 1'b1; add_base = BASE_HEX;
                    end else begin
                        take = 1'b0;
                    end
                end else if (n_mode == MODE_OCT) begin
                    if (dig < 5'd8) begin
                        add = 1'b1; add_base = BASE_OCT;
                    end
                end else begin
                    if (dig < 5'd10) begin
                        add = 1'b1; add_base = BASE_DEC;
                    end
                end
            end
            PH_AUTO_ZERO: begin
                priority if (i_ch == CH_LOW_X || i_ch == CH_UP_X) begin
                    n_base  = BASE_HEX;
                    n_phase = PH_DIGITS;
                    n_ok    = 1'b1;
                    take    = 1'b1;
                end else if (dig < 5'd8) begin
                    add = 1'b1; add_base = BASE_OCT;
                end else begin
                    take = 1'b0;
                end
            end
            PH_HEX_ZERO: begin
                priority if (i_ch == CH_LOW_X || i_ch == CH_UP_X) begin
                    n_base  = BASE_HEX;
                    n_phase = PH_DIGITS;
                    n_ok    = 1'b1;
                    take    = 1'b1;
                end else if (dig < 5'd16) begin
                    add = 1'b1; add_base = BASE_HEX;
                end else begin
                    take = 1'b0;
                end
            end
            PH_DIGITS: begin
                if (dig < base_radix(n_base)) begin
                    add = 1'b1; add_base = n_base;
                end
            end
            default: begin
                take = 1'b0;
            end
        endcase

        // Scale by the radix with shifts; the accumulator already carries the sign.
        unique case (add_base)
            BASE_OCT: acc_scaled = n_acc << 3;
            BASE_HEX: acc_scaled = n_acc << 4;
            default:  acc_scaled = (n_acc << 3) + (n_acc << 1);
        endcase
        dig_ext = VALUE_BITS'(dig);

        if (add) begin
            n_acc   = n_neg ? (acc_scaled - dig_ext) : (acc_scaled + dig_ext);
            n_base  = add_base;
            n_ok    = 1'b1;
            n_phase = PH_DIGITS;
            take    = 1'b1;
        end

        // Count the character and close the field at a reject or the width limit.
        emit = 1'b0;
        if (n_phase != PH_IDLE) begin
            if (!take) begin
                emit = 1'b1;
            end else begin
                if (n_cnt != {CNT_BITS{1'b1}}) begin
                    n_cnt = n_cnt + CNT_BITS'(1);
                end
                if (n_width != '0 && n_cnt >= CNT_BITS'(n_width)) begin
                    emit = 1'b1;
                end
            end
        end
        if (emit) begin
            n_phase = PH_IDLE;
        end

        // Cut the result to the selected size.
        for (int i = 0; i < VALUE_BITS; i++) begin
            unique case (n_size)
                SIZE_WORD:  size_mask[i] = (i < 32);
                SIZE_SHORT: size_mask[i] = (i < 16);
                default:    size_mask[i] = 1'b1;
            endcase
        end
        n_value = n_acc & size_mask;
    end

    // Field state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_ok        <= 1'b0;
            r_base      <= BASE_DEC;
            r_mode      <= MODE_DEC;
            r_width     <= '0;
            r_size      <= SIZE_WORD;
            r_out_valid <= 1'b0;
            r_value     <= '0;
            r_consumed  <= '0;
            r_good      <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_neg   <= n_neg;
                r_ok    <= n_ok;
                r_base  <= n_base;
                r_mode  <= n_mode;
                r_width <= n_width;
                r_size  <= n_size;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
                r_value     <= n_value;
                r_consumed  <= n_cnt;
                r_good      <= n_ok;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_consumed  = r_consumed;
    assign o_good      = r_good;

    // A stalled result blocks new character beats.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("character beat accepted while a result is stalled");

    // A field that read nothing reports a zero value.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_good) |-> (o_value == '0))
        else $error("nonzero value on a field without digits");

    // Without a digit or prefix, at most the sign was consumed.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_good) |-> (o_consumed <= CNT_BITS'(1)))
        else $error("more than a sign consumed on a field without digits");

    // Idle stays idle while no beat arrives.
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && !accept) |=> (r_phase == PH_IDLE))
        else $error("field opened without a character beat");

    // A result is only raised by an accepted beat.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(accept))
        else $error("result raised without an accepted beat");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench: directed and random character beats scored against a built-in field predictor.
import aifs_pkg::*;

// One finished field as the result channel should report it.
typedef struct packed {
    logic [63:0]          value;
    logic [CNT_BITS-1:0]  consumed;
    logic                 good;
} t_field_result;

// Scanner states of the predictor.
typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_AUTO_ZERO,
    ST_HEX_ZERO,
    ST_DIGITS
} t_scan_state;

// Predicts finished fields from accepted character beats and scores result beats.
class scan_scoreboard;
    t_scan_state          state;
    logic [63:0]          accum;
    logic [CNT_BITS-1:0]  count;
    logic                 negative;
    logic                 digits_seen;
    t_base                base;
    t_mode                fmode;
    t_size                fsize;
    logic [7:0]           flimit;
    t_field_result        expected_fields[$];
    int                   errors;

    function new();
        state       = ST_IDLE;
        accum       = '0;
        count       = '0;
        negative    = 1'b0;
        digits_seen = 1'b0;
        base        = BASE_DEC;
        fmode       = MODE_DEC;
        fsize       = SIZE_WORD;
        flimit      = '0;
        errors      = 0;
    endfunction

    function int pending();
        return expected_fields.size();
    endfunction

    // Digit value of a character, DIGIT_NONE when it is no hex digit.
    function logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd16;
        if (c >= CH_ZERO && c <= CH_NINE) t = c - CH_ZERO;
        else if (c >= CH_LOW_A && c <= CH_LOW_F) t = c - CH_LOW_A + 8'd10;
        else if (c >= CH_UP_A && c <= CH_UP_F) t = c - CH_UP_A + 8'd10;
        return t[4:0];
    endfunction

    function logic [4:0] radix_of(input t_base b);
        case (b)
            BASE_OCT: return 5'd8;
            BASE_HEX: return 5'd16;
            default:  return 5'd10;
        endcase
    endfunction

    function void take_digit(input t_base b, input logic [4:0] d);
        accum       = accum * 64'(radix_of(b)) + 64'(d);
        base        = b;
        digits_seen = 1'b1;
        state       = ST_DIGITS;
    endfunction

    // Negate if needed, cut to the field's size and queue the result.
    function void close_field();
        t_field_result r;
        logic [63:0]   v;
        v = negative ? -accum : accum;
        if (fsize == SIZE_WORD) v = {32'd0, v[31:0]};
        else if (fsize == SIZE_SHORT) v = {48'd0, v[15:0]};
        r.value    = v;
        r.consumed = count;
        r.good     = digits_seen;
        expected_fields.push_back(r);
        state = ST_IDLE;
    endfunction

    // Returns 1 when the beat was seen by an open field, 0 when it was ignored.
    function bit note_char(input logic [7:0] c, input logic start, input t_mode m,
                           input t_size s, input logic [7:0] w);
        logic [4:0] d;
        bit         took;
        if (start) begin
            fmode       = (m > MODE_HEX) ? MODE_DEC : m;
            fsize       = s;
            flimit      = w;
            accum       = '0;
            count       = '0;
            negative    = 1'b0;
            digits_seen = 1'b0;
            base        = BASE_DEC;
            state       = ST_LEAD;
        end
        if (state == ST_IDLE) return 1'b0;

        d    = digit_of(c);
        took = 1'b0;
        case (state)
            ST_LEAD: begin
                // Only the very first character may be a sign.
                if ((c == CH_MINUS || c == CH_PLUS) && count == 0) begin
                    negative = (c == CH_MINUS);
                    took     = 1'b1;
                end else if (fmode == MODE_AUTO) begin
                    if (c == CH_ZERO) begin
                        digits_seen = 1'b1;
                        state       = ST_AUTO_ZERO;
                        took        = 1'b1;
                    end else if (d < radix_of(BASE_DEC)) begin
                        take_digit(BASE_DEC, d);
                        took = 1'b1;
                    end
                end else if (fmode == MODE_HEX) begin
                    if (c == CH_ZERO) begin
                        digits_seen = 1'b1;
                        state       = ST_HEX_ZERO;
                        took        = 1'b1;
                    end else if (d < radix_of(BASE_HEX)) begin
                        take_digit(BASE_HEX, d);
                        took = 1'b1;
                    end
                end else if (fmode == MODE_OCT) begin
                    if (d < radix_of(BASE_OCT)) begin
                        take_digit(BASE_OCT, d);
                        took = 1'b1;
                    end
                end else if (d < radix_of(BASE_DEC)) begin
                    take_digit(BASE_DEC, d);
                    took = 1'b1;
                end
            end
            ST_AUTO_ZERO: begin
                if (c == CH_LOW_X || c == CH_UP_X) begin
                    base  = BASE_HEX;
                    state = ST_DIGITS;
                    took  = 1'b1;
                end else if (d < radix_of(BASE_OCT)) begin
                    take_digit(BASE_OCT, d);
                    took = 1'b1;
                end
            end
            ST_HEX_ZERO: begin
                if (c == CH_LOW_X || c == CH_UP_X) begin
                    base  = BASE_HEX;
                    state = ST_DIGITS;
                    took  = 1'b1;
                end else if (d < radix_of(BASE_HEX)) begin
                    take_digit(BASE_HEX, d);
                    took = 1'b1;
                end
            end
            default: begin
                if (d < radix_of(base)) begin
                    take_digit(base, d);
                    took = 1'b1;
                end
            end
        endcase

        // A rejected character ends the field without being consumed.
        if (!took) begin
            close_field();
            return 1'b1;
        end
        if (count != '1) count++;
        if (flimit != 0 && count >= flimit) close_field();
        return 1'b1;
    endfunction

    task report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Compare one result beat with the oldest predicted field.
    task check_result(input logic [63:0] v, input logic [CNT_BITS-1:0] n, input logic g);
        t_field_result want;
        if (expected_fields.size() == 0) begin
            report($sformatf("result with nothing pending: value=%h consumed=%0d good=%0b",
                             v, n, g));
            return;
        end
        want = expected_fields.pop_front();
        if (v !== want.value)
            report($sformatf("value %h, predicted %h", v, want.value));
        if (n !== want.consumed)
            report($sformatf("consumed %0d, predicted %0d", n, want.consumed));
        if (g !== want.good)
            report($sformatf("good %0b, predicted %0b", g, want.good));
    endtask
endclass

module tb;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHAR_TARGET    = 1525;
    localparam int TAIL_CYCLES    = 4;

    localparam t_mode      MODE_UNUSED = 3'd7;
    localparam t_size      SIZE_UNUSED = 2'd3;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_COMMA    = 8'h2c;
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_ch        = 8'd0;
    logic                 i_start_req = 1'b0;
    t_mode                i_mode      = MODE_DEC;
    t_size                i_size_sel  = SIZE_WORD;
    logic [7:0]           i_max_width = 8'd0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [63:0]          o_value;
    logic [CNT_BITS-1:0]  o_consumed;
    logic                 o_good;

    scan_scoreboard sb;
    logic [7:0]     field_text[$];
    int             chars_used   = 0;
    int             idle_cycles  = 0;
    int             burst_left   = 0;
    int             stall_span   = 0;
    int             stall_pct    = 0;
    bit             moved;

    ascii_integer_field_scanner DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_start_req (i_start_req),
        .i_mode      (i_mode),
        .i_size_sel  (i_size_sel),
        .i_max_width (i_max_width),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_consumed  (o_consumed),
        .o_good      (o_good)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Result side: stall rate is redrawn after each span of random length, sometimes no stalls at all.
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(40, 400);
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        stall_span--;
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Score both channels at the rising edge and watch for a stuck handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                if (sb.note_char(i_ch, i_start_req, i_mode, i_size_sel, i_max_width))
                    chars_used++;
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_value, o_consumed, o_good);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Send one character beat; called and returns at a falling edge.
    task automatic put_char(input logic [7:0] c, input logic start, input t_mode m,
                            input t_size s, input logic [7:0] w);
        begin
            // Bursts of random length, most of them followed by a short gap.
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(3) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
            end
            burst_left--;
            i_in_valid  <= 1'b1;
            i_ch        <= c;
            i_start_req <= start;
            i_mode      <= m;
            i_size_sel  <= s;
            i_max_width <= w;
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
        end
    endtask

    // Character inside a field: mode, size and limit are don't-care and get noise.
    task automatic put_next(input logic [7:0] c);
        t_mode m;
        t_size s;
        begin
            m = t_mode'($urandom_range(7));
            s = t_size'($urandom_range(3));
            put_char(c, 1'b0, m, s, 8'($urandom_range(255)));
        end
    endtask

    task automatic load_text(input string txt);
        begin
            field_text = {};
            for (int i = 0; i < txt.len(); i++) field_text.push_back(txt[i]);
        end
    endtask

    // Send field_text as one field opened by its first character.
    task automatic send_text(input t_mode m, input t_size s, input logic [7:0] w);
        begin
            for (int i = 0; i < field_text.size(); i++) begin
                if (i == 0) put_char(field_text[i], 1'b1, m, s, w);
                else put_next(field_text[i]);
            end
        end
    endtask

    // Stop sending until every predicted result has come out.
    task automatic hold_until_drained();
        begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while (sb.pending() != 0);
        end
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'(CH_ZERO + d);
        return 8'(($urandom_range(1) ? CH_LOW_A : CH_UP_A) + d - 10);
    endfunction

    // One random field: mostly well-formed text, sometimes plain noise.
    task automatic send_random_field();
        t_mode m;
        t_size s;
        logic [7:0] w;
        int r;
        int n;
        int radix;
        begin
            if ($urandom_range(9) == 0) begin
                // Noise: random bytes with random field starts.
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    m = t_mode'($urandom_range(7));
                    s = t_size'($urandom_range(3));
                    put_char(8'($urandom_range(255)), $urandom_range(3) == 0, m, s,
                             8'($urandom_range(255)));
                end
            end else begin
                r = $urandom_range(19);
                m = t_mode'((r < 18) ? r % 5 : $urandom_range(5, 7));
                s = t_size'($urandom_range(3));
                r = $urandom_range(9);
                w = (r < 6) ? 8'd0 : (r < 9) ? 8'($urandom_range(1, 6))
                                             : 8'($urandom_range(255));
                field_text = {};

                // Optional sign, rarely doubled.
                r = $urandom_range(9);
                if (r < 3) field_text.push_back(CH_MINUS);
                else if (r < 5) field_text.push_back(CH_PLUS);
                if ($urandom_range(14) == 0)
                    field_text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);

                // Optional prefix, which also fixes the digit radix.
                radix = 10;
                r = $urandom_range(9);
                if (m == MODE_AUTO || m == MODE_HEX) begin
                    if (r < 4 || (m == MODE_HEX && r < 5)) begin
                        field_text.push_back(CH_ZERO);
                        field_text.push_back($urandom_range(1) ? CH_LOW_X : CH_UP_X);
                        radix = 16;
                    end else if (m == MODE_AUTO && r < 6) begin
                        field_text.push_back(CH_ZERO);
                        radix = 8;
                    end else if (m == MODE_HEX) begin
                        radix = 16;
                    end
                end else if (m == MODE_OCT) begin
                    radix = 8;
                end

                // Digits: short runs mostly, long ones to wrap the accumulator.
                r = $urandom_range(9);
                n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(29) == 0) field_text.push_back(8'($urandom_range(255)));
                    else field_text.push_back(digit_char($urandom_range(radix - 1)));
                end

                // Usually a delimiter; otherwise the next field cuts this one off.
                if ($urandom_range(4) != 0 || field_text.size() == 0) begin
                    case ($urandom_range(3))
                        0:       field_text.push_back(CH_SPACE);
                        1:       field_text.push_back(CH_COMMA);
                        2:       field_text.push_back(CH_NEWLINE);
                        default: field_text.push_back(8'($urandom_range(255)));
                    endcase
                end
                send_text(m, s, w);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Negative decimal cut to 16 bits.
        load_text("-9,");
        send_text(MODE_DEC, SIZE_SHORT, 8'd0);
        // Automatic base with a hex prefix under the widest limit.
        load_text("0xF ");
        send_text(MODE_AUTO, SIZE_LONG, 8'd255);
        // Leading zero selects octal; an eight ends the field.
        load_text("078");
        send_text(MODE_AUTO, SIZE_WORD, 8'd0);
        // A sign with no digits, and the unused size code.
        load_text("+x");
        send_text(MODE_OCT, SIZE_UNUSED, 8'd0);
        // Minus in unsigned decimal, ended by the width limit.
        load_text("-5");
        send_text(MODE_UDEC, SIZE_WORD, 8'd2);
        // The limit ends the field right after the leading zero.
        load_text("0");
        send_text(MODE_HEX, SIZE_LONG, 8'd1);
        // Prefix followed by a non-hex character.
        load_text("0Xg");
        send_text(MODE_HEX, SIZE_WORD, 8'd0);
        // Unknown mode with a rejected first character gives an empty field.
        load_text("z");
        send_text(MODE_UNUSED, SIZE_WORD, 8'd0);
        // A character outside any field is ignored.
        put_char(8'h00, 1'b0, MODE_DEC, SIZE_WORD, 8'd0);
        // Restart mid-field, then a second sign is refused.
        load_text("1");
        send_text(MODE_DEC, SIZE_WORD, 8'd0);
        load_text("--");
        send_text(MODE_AUTO, SIZE_SHORT, 8'd0);
        // No sign is taken after a hex prefix.
        load_text("0x-");
        send_text(MODE_AUTO, SIZE_WORD, 8'd0);
        // All-ones character opening a field.
        put_char(8'hFF, 1'b1, MODE_OCT, SIZE_LONG, 8'hFF);
        hold_until_drained();

        // Random fields with an occasional full drain.
        while (chars_used < CHAR_TARGET) begin
            send_random_field();
            if ($urandom_range(59) == 0) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
src/aifs_pkg.sv
src/ascii_integer_field_scanner.sv
sim/tb.sv
